// ===== sv/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PKRQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PKRQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pkrq_pkg.sv =====
`default_nettype none

package pkrq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int CODE_W      = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int COUNT_OUT_W = 7;
  localparam int NUM_FKEYS   = 5;

  localparam logic [CODE_W-1:0] CODE_EXTENDED = 8'hC0;
  localparam logic [CODE_W-1:0] CODE_SELFTEST = 8'hAA;
  localparam logic [CODE_W-1:0] HOST_BYTE_RST = 8'hFF;

  // Bit slots of the host frame and the keypad frame.
  localparam logic [3:0] TX_DATA_BITS  = 4'd8;
  localparam logic [3:0] TX_PARITY_BIT = 4'd8;
  localparam logic [3:0] TX_FRAME_BITS = 4'd10;
  localparam logic [3:0] RX_DATA_FIRST = 4'd1;
  localparam logic [3:0] RX_DATA_LAST  = 4'd8;
  localparam logic [3:0] RX_STOP_BIT   = 4'd10;
  localparam logic [1:0] TRIPLET_LAST  = 2'd2;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [NUM_FKEYS-1:0][CODE_W-1:0] fkey_set_t;

  typedef enum logic [2:0] {
    CMD_EDGE   = 3'd0,
    CMD_READ   = 3'd1,
    CMD_PEEK   = 3'd2,
    CMD_FLUSH  = 3'd3,
    CMD_PUSH   = 3'd4,
    CMD_LOCK   = 3'd5,
    CMD_UNLOCK = 3'd6,
    CMD_NOP    = 3'd7
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOST_BYTE   = 3'd0,
    REG_FKEY_LOCK   = 3'd1,
    REG_FKEY_MULT   = 3'd2,
    REG_FKEY_TURN   = 3'd3,
    REG_FKEY_THREAD = 3'd4,
    REG_FKEY_SELECT = 3'd5
  } reg_idx_t;

  // Line engine status, next-state view.
  typedef struct packed {
    logic  drive;
    logic  level;
    logic  key_push;
    code_t key_code;
  } line_stat_t;

  // One committed beat as seen by the queue.
  typedef struct packed {
    logic  commit;
    cmd_t  cmd;
    code_t push_code;
    logic  rx_push;
    code_t rx_code;
  } q_req_t;

  typedef struct packed {
    logic            key_valid;
    code_t           key_code;
    logic [QC_W-1:0] count;
    logic            locked;
  } q_res_t;

endpackage

`default_nettype wire

// ===== sv/pkrq_if.sv =====
`default_nettype none

interface pkrq_in_if import pkrq_pkg::*; ();
  logic  valid;
  logic  ready;
  cmd_t  command;
  logic  data_line;
  code_t push_code;

  modport source (output valid, command, data_line, push_code, input ready);
  modport sink   (input valid, command, data_line, push_code, output ready);
endinterface

interface pkrq_out_if import pkrq_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   line_drive;
  logic                   line_level;
  logic                   key_valid;
  code_t                  key_code;
  logic [COUNT_OUT_W-1:0] queue_count;
  logic                   locked_flag;

  modport source (output valid, line_drive, line_level, key_valid, key_code,
                  queue_count, locked_flag, input ready);
  modport sink   (input valid, line_drive, line_level, key_valid, key_code,
                  queue_count, locked_flag, output ready);
endinterface

interface pkrq_cfg_if import pkrq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  code_t                data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/pkrq_ram.sv =====
`default_nettype none

// Single-port-write, single-port-read RAM, registered read, write-first.
module pkrq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/pkrq_line.sv =====
`default_nettype none

// PS/2 line engine: host byte out, then keypad frames in.
module pkrq_line import pkrq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       tick,
  input  logic       dline,
  input  logic       host_wr,
  input  code_t      host_data,
  output line_stat_t stat
);

  logic [3:0] tx_idx_r, tx_idx_nxt;
  code_t      tx_shift_r, tx_shift_nxt;
  logic       tx_par_r, tx_par_nxt;
  logic       tx_lvl_r, tx_lvl_nxt;
  logic [3:0] rx_idx_r, rx_idx_nxt;
  code_t      rx_shift_r, rx_shift_nxt;
  logic [1:0] trip_r, trip_nxt;
  logic       push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_idx_r   <= '0;
      tx_shift_r <= HOST_BYTE_RST;
      tx_par_r   <= 1'b0;
      tx_lvl_r   <= 1'b0;
      rx_idx_r   <= '0;
      rx_shift_r <= '0;
      trip_r     <= '0;
    end else begin
      tx_idx_r   <= tx_idx_nxt;
      tx_shift_r <= tx_shift_nxt;
      tx_par_r   <= tx_par_nxt;
      tx_lvl_r   <= tx_lvl_nxt;
      rx_idx_r   <= rx_idx_nxt;
      rx_shift_r <= rx_shift_nxt;
      trip_r     <= trip_nxt;
    end
  end

  always_comb begin
    tx_idx_nxt   = tx_idx_r;
    tx_shift_nxt = tx_shift_r;
    tx_par_nxt   = tx_par_r;
    tx_lvl_nxt   = tx_lvl_r;
    rx_idx_nxt   = rx_idx_r;
    rx_shift_nxt = rx_shift_r;
    trip_nxt     = trip_r;
    push         = 1'b0;
    if (tick) begin
      if (tx_idx_r < TX_FRAME_BITS) begin
        if (tx_idx_r < TX_DATA_BITS) begin
          tx_lvl_nxt   = tx_shift_r[0];
          tx_par_nxt   = tx_par_r ^ tx_shift_r[0];
          tx_shift_nxt = {1'b0, tx_shift_r[CODE_W-1:1]};
        end else if (tx_idx_r == TX_PARITY_BIT) begin
          tx_lvl_nxt = ~tx_par_r;
        end else begin
          tx_lvl_nxt = 1'b0;
        end
        tx_idx_nxt = tx_idx_r + 4'd1;
      end else begin
        if (rx_idx_r >= RX_DATA_FIRST && rx_idx_r <= RX_DATA_LAST) begin
          rx_shift_nxt = {dline, rx_shift_r[CODE_W-1:1]};
        end
        if (rx_idx_r >= RX_STOP_BIT) begin
          if (rx_shift_r != CODE_EXTENDED) begin
            if (trip_r == TRIPLET_LAST) begin
              trip_nxt = '0;
              push     = 1'b1;
            end else begin
              trip_nxt = trip_r + 2'd1;
            end
            if (rx_shift_r == CODE_SELFTEST) begin
              trip_nxt = '0;
            end
          end
          rx_shift_nxt = '0;
          rx_idx_nxt   = '0;
        end else begin
          rx_idx_nxt = rx_idx_r + 4'd1;
        end
      end
    end else if (host_wr && tx_idx_r == '0) begin
      tx_shift_nxt = host_data;
    end
  end

  always_comb begin
    stat.drive    = (tx_idx_nxt < TX_FRAME_BITS);
    stat.level    = stat.drive & tx_lvl_nxt;
    stat.key_push = push;
    stat.key_code = rx_shift_r;
  end

endmodule

`default_nettype wire

// ===== sv/pkrq_queue.sv =====
`default_nettype none

// Key queue: pointers, count and lock around a RAM whose read port
// always holds the entry at the head.
module pkrq_queue import pkrq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_req_t    req,
  input  fkey_set_t fkeys,
  output q_res_t    res
);

  logic [QA_W-1:0] head_r, head_nxt;
  logic [QA_W-1:0] tail_r, tail_nxt;
  logic [QC_W-1:0] cnt_r, cnt_nxt;
  logic            lock_r, lock_nxt;
  logic            we;
  code_t           wdata;
  code_t           head_data;
  logic            is_fkey;
  logic            not_full;

  function automatic logic [QA_W-1:0] wrap_next(input logic [QA_W-1:0] i);
    return (i == QA_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  pkrq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (CODE_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (tail_r),
    .wdata (wdata),
    .raddr (head_nxt),
    .rdata (head_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
      lock_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
      lock_r <= lock_nxt;
    end
  end

  always_comb begin
    is_fkey = 1'b0;
    for (int i = 0; i < NUM_FKEYS; i++) begin
      is_fkey = is_fkey | (fkeys[i] == head_data);
    end
  end

  assign not_full = (cnt_r < QC_W'(QUEUE_DEPTH));

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    lock_nxt      = lock_r;
    we            = 1'b0;
    wdata         = req.push_code;
    res.key_valid = 1'b0;
    res.key_code  = '0;
    if (req.commit) begin
      unique case (req.cmd)
        CMD_EDGE: begin
          if (req.rx_push && not_full) begin
            we       = 1'b1;
            wdata    = req.rx_code;
            tail_nxt = wrap_next(tail_r);
            cnt_nxt  = cnt_r + 1'b1;
          end
        end
        CMD_READ: begin
          if (!lock_r && cnt_r != '0) begin
            head_nxt = wrap_next(head_r);
            if (is_fkey) begin
              // re-queue at the tail; the count is unchanged
              we       = 1'b1;
              wdata    = head_data;
              tail_nxt = wrap_next(tail_r);
            end else begin
              res.key_valid = 1'b1;
              res.key_code  = head_data;
              cnt_nxt       = cnt_r - 1'b1;
            end
          end
        end
        CMD_PEEK: begin
          if (cnt_r != '0) begin
            res.key_valid = 1'b1;
            res.key_code  = head_data;
          end
        end
        CMD_FLUSH: begin
          head_nxt = tail_r;
          cnt_nxt  = '0;
        end
        CMD_PUSH: begin
          if (not_full) begin
            we       = 1'b1;
            tail_nxt = wrap_next(tail_r);
            cnt_nxt  = cnt_r + 1'b1;
          end
        end
        CMD_LOCK:   lock_nxt = 1'b1;
        CMD_UNLOCK: lock_nxt = 1'b0;
        default: ;
      endcase
    end
    res.count  = cnt_nxt;
    res.locked = lock_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/ps2_keypad_receiver_queue_top.sv =====
// Channel   Dir  Payload                                      Beat when
// in_chan   in   command, data_line, push_code                valid & ready
// out_chan  out  line_drive, line_level, key_valid, key_code,  valid & ready
//                queue_count, locked_flag
// cfg_chan  in   index, data (register write)                 valid & ready
//
// Cycles: one beat per cycle unless output stalls; result offered next cycle.
// The key RAM reads the next head entry every cycle, so read and peek find it
// waiting, and pointers, count and RAM all update in the cycle of the beat.
// Reset: rst_n synchronous, active low; no memory clearing pass.
// Stalls: out of reset, in_chan.ready is high while the output register is
// empty or its beat is taken this cycle; cfg_chan.ready is high.
`default_nettype none

module ps2_keypad_receiver_queue_top import pkrq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  pkrq_in_if.sink     in_chan,
  pkrq_out_if.source  out_chan,
  pkrq_cfg_if.sink    cfg_chan
);

  logic       in_beat;
  logic       cfg_beat;
  logic       host_wr;
  fkey_set_t  fkeys_r, fkeys_nxt;
  line_stat_t line_stat;
  q_req_t     q_req;
  q_res_t     q_res;

  // output register
  logic                   out_valid_r;
  logic                   out_drive_r;
  logic                   out_level_r;
  logic                   out_kv_r;
  code_t                  out_code_r;
  logic [COUNT_OUT_W-1:0] out_count_r;
  logic                   out_locked_r;

  // Take a new beat whenever the result slot is free or draining; hold off
  // while in reset.
  assign in_chan.ready = rst_n && (!out_valid_r || out_chan.ready);
  assign in_beat       = in_chan.valid && in_chan.ready;

  assign cfg_chan.ready = rst_n;
  assign cfg_beat       = cfg_chan.valid && cfg_chan.ready;

  // Register writes: host byte goes straight to the line engine, function
  // key codes are held here. Unknown indexes drop.
  always_comb begin
    fkeys_nxt = fkeys_r;
    host_wr   = 1'b0;
    if (cfg_beat) begin
      unique case (cfg_chan.index)
        REG_HOST_BYTE:   host_wr      = 1'b1;
        REG_FKEY_LOCK:   fkeys_nxt[0] = cfg_chan.data;
        REG_FKEY_MULT:   fkeys_nxt[1] = cfg_chan.data;
        REG_FKEY_TURN:   fkeys_nxt[2] = cfg_chan.data;
        REG_FKEY_THREAD: fkeys_nxt[3] = cfg_chan.data;
        REG_FKEY_SELECT: fkeys_nxt[4] = cfg_chan.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fkeys_r <= '0;
    end else begin
      fkeys_r <= fkeys_nxt;
    end
  end

  pkrq_line u_line (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick      (in_beat && (in_chan.command == CMD_EDGE)),
    .dline     (in_chan.data_line),
    .host_wr   (host_wr),
    .host_data (cfg_chan.data),
    .stat      (line_stat)
  );

  always_comb begin
    q_req.commit    = in_beat;
    q_req.cmd       = in_chan.command;
    q_req.push_code = in_chan.push_code;
    q_req.rx_push   = line_stat.key_push;
    q_req.rx_code   = line_stat.key_code;
  end

  pkrq_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (q_req),
    .fkeys (fkeys_r),
    .res   (q_res)
  );

  // Hold the result until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_beat) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      out_drive_r  <= line_stat.drive;
      out_level_r  <= line_stat.level;
      out_kv_r     <= q_res.key_valid;
      out_code_r   <= q_res.key_code;
      out_count_r  <= COUNT_OUT_W'(q_res.count);
      out_locked_r <= q_res.locked;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.line_drive  = out_drive_r;
  assign out_chan.line_level  = out_level_r;
  assign out_chan.key_valid   = out_kv_r;
  assign out_chan.key_code    = out_code_r;
  assign out_chan.queue_count = out_count_r;
  assign out_chan.locked_flag = out_locked_r;

endmodule

`default_nettype wire

// ===== sv/pkrq_chk.sv =====
`default_nettype none
`include "assert_macros.svh"

module pkrq_chk import pkrq_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input cmd_t                   in_command,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   line_drive,
  input logic                   line_level,
  input logic                   key_valid,
  input code_t                  key_code,
  input logic [COUNT_OUT_W-1:0] queue_count,
  input logic                   locked_flag
);

  `PKRQ_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")
  `PKRQ_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(key_code) && $stable(queue_count) && $stable(key_valid), "stalled result changed")
  `PKRQ_ASSERT_IMP(a_released_low, out_valid && !line_drive, !line_level, "level set on released line")
  `PKRQ_ASSERT_IMP(a_nokey_zero, out_valid && !key_valid, key_code == '0, "code without key")
  `PKRQ_ASSERT_NXT(a_lock_seen, in_valid && in_ready && (in_command == CMD_LOCK), out_valid && locked_flag, "lock beat not reflected")

endmodule

bind ps2_keypad_receiver_queue_top pkrq_chk u_pkrq_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .in_command  (in_chan.command),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .line_drive  (out_chan.line_drive),
  .line_level  (out_chan.line_level),
  .key_valid   (out_chan.key_valid),
  .key_code    (out_chan.key_code),
  .queue_count (out_chan.queue_count),
  .locked_flag (out_chan.locked_flag)
);

`default_nettype wire
